// ----- hw/rtl/tsls_pkg.sv -----
// Shared types and constants for the tree serialization length scanner.
// No dependencies; imported by tree_serialization_length_scanner_top.
`default_nettype none

package tsls_pkg;

	localparam int PENDING_BITS_DEF = 32;
	localparam int LENGTH_BITS_DEF  = 40;
	localparam int LEN_OUT_BITS     = 40;
	localparam int SIZE_BITS        = 34;
	localparam int STATUS_BITS      = 3;

	localparam logic [7:0] PAIR_BYTE  = 8'hff;
	localparam logic [7:0] BREF_BYTE  = 8'hfe;
	localparam logic [7:0] SMALL_MAX  = 8'h7f;
	localparam logic [7:0] EMPTY_BYTE = 8'h80;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_NODE,
		PH_BREF,
		PH_SIZE,
		PH_SKIP
	} phase_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK,
		ST_BAD_PREFIX,
		ST_ATOM_LARGE,
		ST_BUF_END,
		ST_PEND_OVF,
		ST_LEN_OVF
	} status_t;

	// Count of leading ones in a byte, 0..8.
	function automatic logic [3:0] lead_ones(input logic [7:0] b);
		logic [3:0] n;
		logic       run;
		n   = 4'd0;
		run = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			if (run && b[i]) begin
				n = n + 4'd1;
			end else begin
				run = 1'b0;
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tree_serialization_length_scanner_top.sv -----
// Top level of the tree serialization length scanner: input register, byte
// decode and parse state, result register. Depends on tsls_pkg.
`default_nettype none

// Usage
//   Input channel: data_byte, start_object, last_in_buffer with in_valid and
//   in_stall. One item is one byte of a serialized tree; start_object marks
//   the first byte of an object, last_in_buffer the last byte available.
//   Output channel: object_length and status with out_valid and out_stall.
//   At most one result comes from each byte: the object length with status 0
//   when the tree closes, or an error status that also ends the parse.
//   Throughput: one byte per cycle while out_stall holds no result, set by the
//   single parse update between the input register and the result register.
//   The result of a byte in the input register goes to the result register.
//   Bytes without start_object while idle are dropped; a new start_object
//   abandons an unfinished parse without a result.
//   Reset (arst_n low) empties both registers and returns the parse to idle.
//   While out_stall holds a result, one more byte is taken into the input
//   register; in_stall then rises until the result is taken.
module tree_serialization_length_scanner_top
	import tsls_pkg::*;
#(
	parameter int PENDING_BITS = PENDING_BITS_DEF,
	parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire  [7:0]              data_byte,
	input  wire                     start_object,
	input  wire                     last_in_buffer,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [LEN_OUT_BITS-1:0] object_length,
	output logic [STATUS_BITS-1:0]  status
);

	localparam logic [PENDING_BITS-1:0] PEND_MAX = {PENDING_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0]  LEN_MAX  = {LENGTH_BITS{1'b1}};

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       last_s1;

	// parse state
	phase_t                  phase_q, phase_n;
	logic [PENDING_BITS-1:0] pend_q, pend_n;
	logic [2:0]              left_q, left_n;
	logic [SIZE_BITS-1:0]    sval_q, sval_n;
	logic                    big_q, big_n;
	logic [SIZE_BITS-1:0]    skip_q, skip_n;
	logic [LENGTH_BITS-1:0]  len_q, len_n;

	// result register
	logic                    out_valid_q;
	logic [LEN_OUT_BITS-1:0] olen_q;
	status_t                 status_q;

	logic                advance;
	logic                run;
	logic                emit;
	status_t             est;
	logic                size_chk;
	logic                node_chk;
	logic [3:0]          ones;
	logic [SIZE_BITS+7:0] shifted;

	assign in_stall      = valid_s1 && out_valid_q && out_stall;
	assign advance       = valid_s1 && !(out_valid_q && out_stall);
	assign out_valid     = out_valid_q;
	assign object_length = olen_q;
	assign status        = status_q;
	assign ones          = lead_ones(byte_s1);
	assign shifted       = {sval_q, byte_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= data_byte;
			start_s1 <= start_object;
			last_s1  <= last_in_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pend_q  <= '0;
			left_q  <= '0;
			sval_q  <= '0;
			big_q   <= 1'b0;
			skip_q  <= '0;
			len_q   <= '0;
		end else begin
			phase_q <= phase_n;
			pend_q  <= pend_n;
			left_q  <= left_n;
			sval_q  <= sval_n;
			big_q   <= big_n;
			skip_q  <= skip_n;
			len_q   <= len_n;
		end
	end

	always_comb begin
		phase_n  = phase_q;
		pend_n   = pend_q;
		left_n   = left_q;
		sval_n   = sval_q;
		big_n    = big_q;
		skip_n   = skip_q;
		len_n    = len_q;
		run      = 1'b0;
		emit     = 1'b0;
		est      = ST_OK;
		size_chk = 1'b0;
		node_chk = 1'b0;

		if (advance) begin
			run = 1'b1;
			if (start_s1) begin
				phase_n = PH_NODE;
				pend_n  = PENDING_BITS'(1);
				left_n  = '0;
				sval_n  = '0;
				big_n   = 1'b0;
				skip_n  = '0;
				len_n   = '0;
			end else if (phase_q == PH_IDLE) begin
				run = 1'b0;
			end
		end

		if (run) begin
			if (len_n == LEN_MAX) begin
				emit = 1'b1;
				est  = ST_LEN_OVF;
			end else begin
				len_n = len_n + LENGTH_BITS'(1);
				case (phase_n)
					PH_NODE: begin
						pend_n = pend_n - PENDING_BITS'(1);
						if (byte_s1 == PAIR_BYTE) begin
							if (pend_n == PEND_MAX || pend_n == PEND_MAX - PENDING_BITS'(1)) begin
								emit = 1'b1;
								est  = ST_PEND_OVF;
							end else begin
								pend_n = pend_n + PENDING_BITS'(2);
							end
						end else if (byte_s1 == BREF_BYTE) begin
							phase_n = PH_BREF;
						end else if (byte_s1 == EMPTY_BYTE || byte_s1 <= SMALL_MAX) begin
							node_chk = 1'b1;
						end else begin
							sval_n = SIZE_BITS'(byte_s1 & (8'hff >> ones));
							big_n  = 1'b0;
							left_n = 3'(ones - 4'd1);
							if (left_n == 3'd0) begin
								size_chk = 1'b1;
							end else begin
								phase_n = PH_SIZE;
							end
						end
					end
					PH_BREF: begin
						if (byte_s1 <= SMALL_MAX) begin
							node_chk = 1'b1;
						end else if (ones == 4'd8) begin
							emit = 1'b1;
							est  = ST_BAD_PREFIX;
						end else begin
							sval_n = SIZE_BITS'(byte_s1 & (8'hff >> ones));
							big_n  = 1'b0;
							left_n = 3'(ones - 4'd1);
							if (left_n == 3'd0) begin
								size_chk = 1'b1;
							end else begin
								phase_n = PH_SIZE;
							end
						end
					end
					PH_SIZE: begin
						// keep the low bits, remember the overflow
						sval_n = shifted[SIZE_BITS-1:0];
						big_n  = big_q || (shifted[SIZE_BITS+7:SIZE_BITS] != 8'd0);
						left_n = left_q - 3'd1;
						if (left_n == 3'd0) begin
							size_chk = 1'b1;
						end
					end
					PH_SKIP: begin
						if (skip_n != '0) begin
							skip_n = skip_n - SIZE_BITS'(1);
						end
						if (skip_n == '0) begin
							node_chk = 1'b1;
						end
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase

				if (size_chk) begin
					if (big_n) begin
						emit = 1'b1;
						est  = ST_ATOM_LARGE;
					end else begin
						skip_n = sval_n;
						if (sval_n == '0) begin
							node_chk = 1'b1;
						end else begin
							phase_n = PH_SKIP;
						end
					end
				end

				if (node_chk) begin
					if (pend_n == '0) begin
						emit = 1'b1;
						est  = ST_OK;
					end else begin
						phase_n = PH_NODE;
					end
				end

				if (!emit && last_s1) begin
					emit = 1'b1;
					est  = ST_BUF_END;
				end
			end
			if (emit) begin
				phase_n = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			olen_q   <= LEN_OUT_BITS'(len_n);
			status_q <= est;
		end
	end

	// a stall upstream only comes from a held result and a full input register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && valid_s1))
		else $error("input stalled without a held result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_NODE) |-> (pend_q != '0))
		else $error("node phase with no pending node");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (skip_q != '0))
		else $error("skip phase with nothing to skip");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SIZE) |-> (left_q != 3'd0))
		else $error("size phase with no size bytes left");

endmodule

`default_nettype wire

// ----- dv/tb_tree_serialization_length_scanner_top.sv -----
// Testbench for tree_serialization_length_scanner_top: directed byte table, then random
// trees, truncated and broken buffers and noise; results checked against table or model.
// Depends on tsls_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module tb_tree_serialization_length_scanner_top;
	import tsls_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int TARGET_BYTES = 900;
	localparam logic [LENGTH_BITS_DEF-1:0]  LEN_MAX    = '1;
	localparam logic [PENDING_BITS_DEF-1:0] PEND_MAX   = '1;
	localparam logic [41:0]                 SIZE_LIMIT = 42'h4_0000_0000;

	typedef struct packed {
		logic [7:0] data;
		logic       st;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic [LEN_OUT_BITS-1:0] len;
		status_t                 status;
	} result_t;

	typedef struct packed {
		logic [7:0]              data;
		logic                    st;
		logic                    last;
		bit                      typed;
		logic [LEN_OUT_BITS-1:0] len;
		status_t                 status;
	} dir_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [7:0]              data_byte;
	logic                    start_object;
	logic                    last_in_buffer;
	logic                    out_valid;
	logic                    out_stall;
	logic [LEN_OUT_BITS-1:0] object_length;
	logic [STATUS_BITS-1:0]  status;

	// model of the scan state
	phase_t                      sc_phase     = PH_IDLE;
	logic [PENDING_BITS_DEF-1:0] sc_pend      = '0;
	logic [2:0]                  sc_size_left = '0;
	logic [SIZE_BITS-1:0]        sc_size_val  = '0;
	bit                          sc_size_big  = 1'b0;
	logic [SIZE_BITS-1:0]        sc_skip      = '0;
	logic [LENGTH_BITS_DEF-1:0]  sc_len       = '0;

	result_t    expected_lengths[$];
	byte_item_t obj_q[$];
	bit         obj_closed;
	bit         tx_burst = 1'b0;
	int         fed_bytes = 0;
	int         mismatch_count = 0;
	int         idle_cycles = 0;

	dir_row_t directed_rows [25] = '{
		'{8'h05, 1'b0, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'h00, 1'b1, 1'b0, 1'b1, 40'd1, ST_OK},
		'{8'h80, 1'b1, 1'b0, 1'b1, 40'd1, ST_OK},
		'{8'hff, 1'b1, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'h7f, 1'b0, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'hfe, 1'b0, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'h05, 1'b0, 1'b0, 1'b1, 40'd4, ST_OK},
		'{8'hfe, 1'b1, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'hff, 1'b0, 1'b0, 1'b1, 40'd2, ST_BAD_PREFIX},
		'{8'h81, 1'b1, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'haa, 1'b0, 1'b0, 1'b1, 40'd2, ST_OK},
		'{8'hc0, 1'b1, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'h02, 1'b0, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'h11, 1'b0, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'h22, 1'b0, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'hfd, 1'b1, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'h00, 1'b0, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'h00, 1'b0, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'h00, 1'b0, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'h00, 1'b0, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'h00, 1'b0, 1'b0, 1'b1, 40'd6, ST_ATOM_LARGE},
		'{8'hff, 1'b1, 1'b1, 1'b1, 40'd1, ST_BUF_END},
		'{8'hff, 1'b1, 1'b0, 1'b0, 40'd0, ST_OK},
		'{8'h00, 1'b1, 1'b0, 1'b1, 40'd1, ST_OK},
		'{8'h3c, 1'b0, 1'b1, 1'b0, 40'd0, ST_OK}
	};

	tree_serialization_length_scanner_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.start_object   (start_object),
		.last_in_buffer (last_in_buffer),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.object_length  (object_length),
		.status         (status)
	);

	always #1 clk = ~clk;

	// Advance the scan state by one byte; counted is low for a byte dropped while idle.
	task automatic scan_byte(input logic [7:0] b, input logic st, input logic last,
			output bit counted, output bit has_res, output result_t res);
		logic [41:0] acc;
		int          ones;
		bit          close_node;
		bit          open_size;
		bit          size_end;
		has_res    = 1'b0;
		res.status = ST_OK;
		close_node = 1'b0;
		open_size  = 1'b0;
		size_end   = 1'b0;
		counted    = st || sc_phase != PH_IDLE;
		if (counted) begin
			if (st) begin
				sc_phase     = PH_NODE;
				sc_pend      = 1;
				sc_size_left = '0;
				sc_size_val  = '0;
				sc_size_big  = 1'b0;
				sc_skip      = '0;
				sc_len       = '0;
			end
			if (sc_len == LEN_MAX) begin
				has_res    = 1'b1;
				res.status = ST_LEN_OVF;
			end else begin
				sc_len = sc_len + 1;
				ones = 0;
				for (int i = 7; i >= 0; i--) begin
					if (!b[i])
						break;
					ones++;
				end
				case (sc_phase)
					PH_NODE: begin
						sc_pend = sc_pend - 1;
						if (b == PAIR_BYTE) begin
							if (sc_pend > PEND_MAX - 2) begin
								has_res    = 1'b1;
								res.status = ST_PEND_OVF;
							end else begin
								sc_pend = sc_pend + 2;
							end
						end else if (b == BREF_BYTE) begin
							sc_phase = PH_BREF;
						end else if (b == EMPTY_BYTE || b <= SMALL_MAX) begin
							close_node = 1'b1;
						end else begin
							open_size = 1'b1;
						end
					end
					PH_BREF: begin
						if (b <= SMALL_MAX) begin
							close_node = 1'b1;
						end else if (ones == 8) begin
							has_res    = 1'b1;
							res.status = ST_BAD_PREFIX;
						end else begin
							open_size = 1'b1;
						end
					end
					PH_SIZE: begin
						acc = ({8'h00, sc_size_val} << 8) | b;
						if (acc >= SIZE_LIMIT)
							sc_size_big = 1'b1;
						sc_size_val  = acc[SIZE_BITS-1:0];
						sc_size_left = sc_size_left - 3'd1;
						size_end     = (sc_size_left == 0);
					end
					PH_SKIP: begin
						if (sc_skip != 0)
							sc_skip = sc_skip - 1;
						close_node = (sc_skip == 0);
					end
					default: begin
						sc_phase = PH_IDLE;
					end
				endcase
				if (open_size) begin
					sc_size_val  = SIZE_BITS'(b & (8'hff >> ones));
					sc_size_big  = 1'b0;
					sc_size_left = 3'(ones - 1);
					if (sc_size_left == 0)
						size_end = 1'b1;
					else
						sc_phase = PH_SIZE;
				end
				if (size_end) begin
					if (sc_size_big) begin
						has_res    = 1'b1;
						res.status = ST_ATOM_LARGE;
					end else begin
						sc_skip = sc_size_val;
						if (sc_skip == 0)
							close_node = 1'b1;
						else
							sc_phase = PH_SKIP;
					end
				end
				if (close_node) begin
					if (sc_pend == 0) begin
						has_res    = 1'b1;
						res.status = ST_OK;
					end else begin
						sc_phase = PH_NODE;
					end
				end
				if (!has_res && last) begin
					has_res    = 1'b1;
					res.status = ST_BUF_END;
				end
			end
			if (has_res)
				sc_phase = PH_IDLE;
		end
		res.len = sc_len;
	endtask

	// Present one item, wait for it to be taken, then record what it should produce.
	task automatic feed_byte(input byte_item_t it, input bit typed, input result_t typed_res);
		int      gap;
		bit      counted;
		bit      has_res;
		result_t res;
		gap = tx_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= it.data;
		start_object   <= it.st;
		last_in_buffer <= it.last;
		do @(posedge clk); while (in_stall);
		scan_byte(it.data, it.st, it.last, counted, has_res, res);
		if (counted)
			fed_bytes++;
		if (typed)
			expected_lengths.push_back(typed_res);
		else if (has_res)
			expected_lengths.push_back(res);
	endtask

	task automatic put_byte(input logic [7:0] b);
		obj_q.push_back('{data: b, st: 1'b0, last: 1'b0});
	endtask

	// Append a size-prefixed atom with this many leading ones, and its payload unless huge.
	task automatic add_sized(input int ones, input bit huge);
		logic [63:0] val;
		int          nbits;
		nbits = (7 - ones) + 8 * (ones - 1);
		if (huge)
			val = {$urandom, $urandom} | (64'h1 << (nbits - 1));
		else if ($urandom_range(0, 7) == 0)
			val = 64'($urandom_range(5, 40));
		else
			val = 64'($urandom_range(0, 4));
		val = val & ((64'h1 << nbits) - 64'h1);
		put_byte(8'((64'hff << (8 - ones)) | (val >> (8 * (ones - 1)))));
		for (int k = ones - 2; k >= 0; k--)
			put_byte(8'(val >> (8 * k)));
		if (huge)
			obj_closed = 1'b1;
		else
			repeat (val) put_byte(8'($urandom));
	endtask

	initial begin
		int pend;
		int pick;
		int n;
		int cut;
		int kind;
		int objects;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		data_byte      <= 8'h00;
		start_object   <= 1'b0;
		last_in_buffer <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			feed_byte('{directed_rows[i].data, directed_rows[i].st, directed_rows[i].last},
				directed_rows[i].typed, '{directed_rows[i].len, directed_rows[i].status});

		objects = 0;
		while (fed_bytes < TARGET_BYTES) begin
			if ($urandom_range(0, 5) == 0)
				tx_burst = !tx_burst;
			// drain the block completely now and then
			if (objects % 150 == 75) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (expected_lengths.size() != 0);
			end
			obj_q.delete();
			kind = $urandom_range(0, 99);
			if (kind >= 94) begin
				repeat ($urandom_range(1, 8))
					obj_q.push_back('{8'($urandom), $urandom_range(0, 3) == 0,
						$urandom_range(0, 3) == 0});
			end else begin
				obj_closed = 1'b0;
				pend = 1;
				while (pend > 0 && !obj_closed) begin
					pend--;
					pick = $urandom_range(0, 99);
					if (pick < 30 && obj_q.size() < 60) begin
						put_byte(PAIR_BYTE);
						pend += 2;
					end else if (pick < 55) begin
						if ($urandom_range(0, 5) == 0)
							put_byte(EMPTY_BYTE);
						else
							put_byte(8'($urandom_range(0, SMALL_MAX)));
					end else if (pick < 68) begin
						put_byte(BREF_BYTE);
						put_byte(8'($urandom_range(0, SMALL_MAX)));
					end else if (pick < 78) begin
						put_byte(BREF_BYTE);
						n = $urandom_range(1, 7);
						add_sized(n, n >= 6 && $urandom_range(0, 3) == 0);
					end else begin
						n = $urandom_range(1, 6);
						add_sized(n, n == 6 && $urandom_range(0, 4) == 0);
					end
				end
				cut = $urandom_range(0, obj_q.size() - 1);
				if (kind >= 88) begin
					// abandon: the next start mark cuts this one off
					while (obj_q.size() > cut + 1)
						obj_q.delete(obj_q.size() - 1);
				end else if (kind >= 80) begin
					while (obj_q.size() > cut)
						obj_q.delete(obj_q.size() - 1);
					put_byte(BREF_BYTE);
					put_byte(PAIR_BYTE);
				end else if (kind >= 70) begin
					while (obj_q.size() > cut + 1)
						obj_q.delete(obj_q.size() - 1);
					obj_q[cut].last = 1'b1;
				end else if ($urandom_range(0, 3) == 0) begin
					obj_q[obj_q.size() - 1].last = 1'b1;
				end
				obj_q[0].st = 1'b1;
			end
			// stray bytes with no start mark
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 2))
					feed_byte('{8'($urandom), 1'b0, $urandom_range(0, 1) == 1}, 1'b0, '0);
			foreach (obj_q[i])
				feed_byte(obj_q[i], 1'b0, '0);
			objects++;
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (expected_lengths.size() != 0);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int hold;
		bit rx_burst;
		rx_burst = 1'b0;
		out_stall <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_burst = !rx_burst;
			hold = rx_burst ? 0 : $urandom_range(0, 19);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_lengths.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: length %0d status %0d", object_length, status);
			end else begin
				want = expected_lengths.pop_front();
				if (object_length !== want.len || status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: length exp %0d got %0d, status exp %0d got %0d",
							want.len, object_length, want.status, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

// ----- tree_serialization_length_scanner_top.f -----
hw/rtl/tsls_pkg.sv
hw/rtl/tree_serialization_length_scanner_top.sv
dv/tb_tree_serialization_length_scanner_top.sv
